// ----- rtl/cspc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cspc_pkg
// Shared constants for the cross stencil peak counter: widths, line store
// depth, configuration register indexes, reset values and geometry limits.
// ----------------------------------------------------------------------------
package cspc_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    localparam int PIX_W     = 8;
    localparam int FWIDTH_W  = 11;
    localparam int FHEIGHT_W = 16;
    localparam int THRESH_W  = 11;
    localparam int SUM_W     = 11;
    localparam int CNT_W     = 27;
    localparam int OUT_W     = 26;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd2;

    localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST    = 11'd8;
    localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST   = 16'd6;
    localparam logic [THRESH_W-1:0]  PEAK_THRESHOLD_RST = 11'd30;

    localparam logic [FWIDTH_W-1:0]  MIN_WIDTH  = 11'd3;
    localparam logic [FWIDTH_W-1:0]  MAX_WIDTH_V = FWIDTH_W'(MAX_WIDTH);
    localparam logic [FHEIGHT_W-1:0] MIN_HEIGHT = 16'd3;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

endpackage
`default_nettype wire

// ----- rtl/cross_stencil_peak_counter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cross_stencil_peak_counter_top
// Counts interior pixels of a raster frame whose five-point cross sum exceeds
// a threshold, and gives out the count after the last pixel of each frame.
//
//   channel  | handshake           | word
//   ---------+---------------------+-------------------------------
//   input    | in_valid / in_stall | pixel (8 bits)
//   output   | out_valid/out_stall | peak_count (26 bits), per frame
//   config   | cfg_we              | cfg_index, cfg_wdata
//
// One pixel per clock while not stalled; after a frame's last pixel is taken,
// its count passes the sum stage behind the line store read, then the count
// stage. Reset clears positions, the centre tap and count; line stores hold
// junk until written. The input stalls only on a frame's last pixel while an
// earlier count still waits at the output or in the pipeline.
// ----------------------------------------------------------------------------
module cross_stencil_peak_counter_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [cspc_pkg::PIX_W-1:0]          pixel,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [cspc_pkg::OUT_W-1:0]               peak_count,
    input  wire logic                                cfg_we,
    input  wire logic [cspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cspc_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

    localparam int AW = cspc_pkg::ADDR_W;
    localparam int PW = cspc_pkg::PIX_W;

    // configuration
    logic [cspc_pkg::FWIDTH_W-1:0]  frame_width_reg;
    logic [cspc_pkg::FHEIGHT_W-1:0] frame_height_reg;
    logic [cspc_pkg::THRESH_W-1:0]  peak_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= cspc_pkg::FRAME_WIDTH_RST;
            frame_height_reg   <= cspc_pkg::FRAME_HEIGHT_RST;
            peak_threshold_reg <= cspc_pkg::PEAK_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cspc_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_wdata[cspc_pkg::FWIDTH_W-1:0];
                cspc_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_wdata[cspc_pkg::FHEIGHT_W-1:0];
                cspc_pkg::REG_PEAK_THRESHOLD:
                    peak_threshold_reg <= cfg_wdata[cspc_pkg::THRESH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // effective geometry
    logic [cspc_pkg::FWIDTH_W-1:0]  eff_w;
    logic [cspc_pkg::FHEIGHT_W-1:0] eff_h;

    always_comb
    begin
        if (frame_width_reg < cspc_pkg::MIN_WIDTH)
            eff_w = cspc_pkg::MIN_WIDTH;
        else if (frame_width_reg > cspc_pkg::MAX_WIDTH_V)
            eff_w = cspc_pkg::MAX_WIDTH_V;
        else
            eff_w = frame_width_reg;
        eff_h = (frame_height_reg < cspc_pkg::MIN_HEIGHT) ? cspc_pkg::MIN_HEIGHT
                                                           : frame_height_reg;
    end

    // position
    logic [AW-1:0]                  col_reg, col_next;
    logic [cspc_pkg::FHEIGHT_W-1:0] row_reg, row_next;
    logic [cspc_pkg::FWIDTH_W-1:0]  col_ext, w_m1, c_ext, c_p1;
    logic [AW-1:0]                  c_addr, r_addr;
    logic                           row_end, frame_end, eval_now, right_ok;
    logic                           accept;

    always_comb
    begin
        col_ext   = {1'b0, col_reg};
        w_m1      = eff_w - 11'd1;
        c_ext     = (col_ext >= eff_w) ? w_m1 : col_ext;
        c_addr    = c_ext[AW-1:0];
        c_p1      = c_ext + 11'd1;
        r_addr    = c_p1[AW-1:0];
        right_ok  = (c_p1 < eff_w);
        row_end   = ((col_ext + 11'd1) >= eff_w);
        frame_end = row_end &&
                    (({1'b0, row_reg} + 17'd1) >= {1'b0, eff_h});
        eval_now  = (row_reg >= 16'd2) && (c_ext >= 11'd1) &&
                    ((c_ext + 11'd2) <= eff_w);
        col_next  = row_end ? '0 : col_reg + 10'd1;
        if (!row_end)
            row_next = row_reg;
        else if (frame_end)
            row_next = '0;
        else
            row_next = row_reg + 16'd1;
    end

    // pipeline flags
    logic s1_valid_reg, s1_last_reg, s1_eval_reg, s1_right_ok_reg;
    logic s2_valid_reg, s2_last_reg, s2_hit_reg;
    logic out_valid_reg;

    assign in_stall  = frame_end &&
                       (out_valid_reg || (s1_valid_reg && s1_last_reg) ||
                        (s2_valid_reg && s2_last_reg));
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores
    logic [PW-1:0] older_mem  [cspc_pkg::MAX_WIDTH];
    logic [PW-1:0] middle_mem [cspc_pkg::MAX_WIDTH];
    logic [PW-1:0] up_rd_reg, mid_rd_reg, right_rd_reg;
    logic [PW-1:0] s1_pixel_reg;
    logic [AW-1:0] s1_addr_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg          <= older_mem[c_addr];
            mid_rd_reg         <= middle_mem[c_addr];
            right_rd_reg       <= middle_mem[r_addr];
            middle_mem[c_addr] <= pixel;
            s1_pixel_reg       <= pixel;
            s1_addr_reg        <= c_addr;
        end
    end

    // older row takes the centre value read for the same column
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            older_mem[s1_addr_reg] <= mid_rd_reg;
    end

    // cross sum
    logic [PW-1:0]                 centre_tap_reg;
    logic [PW-1:0]                 right_val;
    logic [cspc_pkg::SUM_W-1:0]    cross_sum;

    always_comb
    begin
        right_val = s1_right_ok_reg ? right_rd_reg : '0;
        cross_sum = cspc_pkg::SUM_W'(centre_tap_reg) + cspc_pkg::SUM_W'(mid_rd_reg)
                  + cspc_pkg::SUM_W'(right_val) + cspc_pkg::SUM_W'(up_rd_reg)
                  + cspc_pkg::SUM_W'(s1_pixel_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_last_reg     <= 1'b0;
            s1_eval_reg     <= 1'b0;
            s1_right_ok_reg <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s2_last_reg     <= 1'b0;
            s2_hit_reg      <= 1'b0;
            centre_tap_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_last_reg     <= frame_end;
                s1_eval_reg     <= eval_now;
                s1_right_ok_reg <= right_ok;
            end
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                s2_last_reg    <= s1_last_reg;
                s2_hit_reg     <= s1_eval_reg && (cross_sum > peak_threshold_reg);
                centre_tap_reg <= mid_rd_reg;
            end
        end
    end

    // count and result
    logic [cspc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [cspc_pkg::OUT_W-1:0] peak_count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (s2_hit_reg && (count_reg != cspc_pkg::COUNT_MAX))
            count_next = count_reg + 27'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    count_reg     <= '0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_last_reg)
            peak_count_reg <= count_next[cspc_pkg::OUT_W-1:0];
    end

    assign peak_count = peak_count_reg;

endmodule
`default_nettype wire

// ----- bench/tb_cross_stencil_peak_counter_top.sv -----
// ----------------------------------------------------------------------------
// tb_cross_stencil_peak_counter_top
// Self-checking bench for the five-point cross peak counter. A short table of
// frames with hand-worked counts comes first. Random frames follow under four
// idling regimes. Count words of random frames are compared with a bit-true
// software copy of the line stores and window taps; table ones with the table.
// ----------------------------------------------------------------------------
module tb_cross_stencil_peak_counter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 1450;
    localparam logic [cspc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [2:0] WR_WIDTH  = 3'b001;
    localparam logic [2:0] WR_HEIGHT = 3'b010;
    localparam logic [2:0] WR_THRESH = 3'b100;
    localparam logic [2:0] WR_ALL    = 3'b111;

    typedef enum int {PIX_UNIFORM, PIX_BRIGHT, PIX_DARK, PIX_RAILS, PIX_MIXED} pix_style_t;

    typedef struct packed {
        logic [2:0]                     writes;
        logic [15:0]                    width_val;
        logic [15:0]                    height_val;
        logic [15:0]                    thresh_val;
        logic [cspc_pkg::PIX_W-1:0]     fill;
        logic [cspc_pkg::PIX_W-1:0]     centre;
        logic [cspc_pkg::OUT_W-1:0]     count;
    } frame_case_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [cspc_pkg::PIX_W-1:0]       pixel;
    logic                             out_valid;
    logic                             out_stall;
    logic [cspc_pkg::OUT_W-1:0]       peak_count;
    logic                             cfg_we;
    logic [cspc_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [cspc_pkg::CFG_DAT_W-1:0]   cfg_wdata;

    // software copy of the block
    logic [cspc_pkg::FWIDTH_W-1:0]    cfg_width;
    logic [cspc_pkg::FHEIGHT_W-1:0]   cfg_height;
    logic [cspc_pkg::THRESH_W-1:0]    cfg_thresh;
    bit   [cspc_pkg::PIX_W-1:0]       older_row [cspc_pkg::MAX_WIDTH];
    bit   [cspc_pkg::PIX_W-1:0]       middle_row [cspc_pkg::MAX_WIDTH];
    bit   [cspc_pkg::PIX_W-1:0]       mid_taps [3];
    int                               col_pos;
    int                               row_pos;
    logic [cspc_pkg::CNT_W-1:0]       peaks;

    logic [cspc_pkg::OUT_W-1:0]       expected_counts [$];
    bit                               use_typed;
    logic [cspc_pkg::OUT_W-1:0]       typed_count;
    int                               pixels_sent;
    int                               snd_idle_pct;
    int                               rcv_stall_pct;
    int                               mismatches;

    frame_case_t directed_cases [4] = '{
        // reset width and threshold: one interior row of six crosses, 35 each
        '{WR_HEIGHT, 16'd0, 16'd3, 16'd0, 8'd7, 8'd7, 26'd6},
        // narrow width and short height clamp to 3x3; 1275 beats 1274
        '{WR_ALL, 16'd0, 16'd0, 16'd1274, 8'd255, 8'd255, 26'd1},
        // sum equal to threshold is not a peak
        '{WR_ALL, 16'd2, 16'd2, 16'd1275, 8'd255, 8'd255, 26'd0},
        '{WR_ALL, 16'd3, 16'd3, 16'd0, 8'd0, 8'd1, 26'd1}
    };

    cross_stencil_peak_counter_top uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .peak_count (peak_count),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what,
                                   input logic [cspc_pkg::OUT_W-1:0] got,
                                   input logic [cspc_pkg::OUT_W-1:0] want);
        $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int eff_width();
        if (cfg_width < cspc_pkg::MIN_WIDTH)
            return int'(cspc_pkg::MIN_WIDTH);
        if (cfg_width > cspc_pkg::MAX_WIDTH_V)
            return int'(cspc_pkg::MAX_WIDTH_V);
        return int'(cfg_width);
    endfunction

    function automatic int eff_height();
        return (cfg_height < cspc_pkg::MIN_HEIGHT) ? int'(cspc_pkg::MIN_HEIGHT)
                                                   : int'(cfg_height);
    endfunction

    // advances the copy by one pixel; returns 1 on the last pixel of a frame
    function automatic bit predict_pixel(input logic [cspc_pkg::PIX_W-1:0] p,
                                         output logic [cspc_pkg::OUT_W-1:0] count_out);
        int w;
        int h;
        int c;
        int sum;
        bit [cspc_pkg::PIX_W-1:0] up;
        bit [cspc_pkg::PIX_W-1:0] right;
        bit done;
        w = eff_width();
        h = eff_height();
        c = (col_pos >= w) ? w - 1 : col_pos;
        up = older_row[c];
        right = (c + 1 < w) ? middle_row[c + 1] : '0;
        mid_taps[0] = mid_taps[1];
        mid_taps[1] = middle_row[c];
        mid_taps[2] = right;
        if (row_pos >= 2 && c >= 1 && c + 2 <= w)
        begin
            sum = int'(mid_taps[0]) + int'(mid_taps[1]) + int'(mid_taps[2])
                + int'(up) + int'(p);
            if (sum > int'(cfg_thresh) && peaks < cspc_pkg::COUNT_MAX)
                peaks++;
        end
        older_row[c] = mid_taps[1];
        middle_row[c] = p;
        done = 1'b0;
        count_out = '0;
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h)
            begin
                count_out = peaks[cspc_pkg::OUT_W-1:0];
                done = 1'b1;
                peaks = '0;
                row_pos = 0;
            end
            else
                row_pos++;
        end
        else
            col_pos++;
        return done;
    endfunction

    function automatic logic [cspc_pkg::PIX_W-1:0] pick_pixel(input pix_style_t s);
        case (s)
            PIX_UNIFORM: return 8'($urandom_range(255));
            PIX_BRIGHT:  return 8'($urandom_range(255, 180));
            PIX_DARK:    return 8'($urandom_range(60));
            default:     return $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    function automatic logic [15:0] pick_width();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 70)
            v = $urandom_range(10, 3);
        else if (r < 85)
            v = $urandom_range(2);
        else
            v = $urandom_range(40, 11);
        return {5'($urandom), 11'(v)};
    endfunction

    function automatic logic [15:0] pick_height();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(6, 3));
        if (r < 85)
            return 16'($urandom_range(2));
        return 16'($urandom_range(12, 7));
    endfunction

    function automatic logic [15:0] pick_threshold();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return {5'($urandom), 11'($urandom_range(1100, 300))};
        if (r < 85)
            return 16'($urandom);
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'd2047;
            2:       return 16'd1274;
            default: return 16'd1275;
        endcase
    endfunction

    task automatic send_pixel(input logic [cspc_pkg::PIX_W-1:0] p);
        logic [cspc_pkg::OUT_W-1:0] cnt;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_pixel(p, cnt))
            expected_counts.insert(expected_counts.size(), use_typed ? typed_count : cnt);
        pixels_sent++;
    endtask

    task automatic reg_write(input logic [cspc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge clk);
        case (idx)
            cspc_pkg::REG_FRAME_WIDTH:    cfg_width = d[cspc_pkg::FWIDTH_W-1:0];
            cspc_pkg::REG_FRAME_HEIGHT:   cfg_height = d[cspc_pkg::FHEIGHT_W-1:0];
            cspc_pkg::REG_PEAK_THRESHOLD: cfg_thresh = d[cspc_pkg::THRESH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [2:0] writes, input logic [15:0] w,
                               input logic [15:0] h, input logic [15:0] t);
        if ($urandom_range(9) == 0)
            reg_write(REG_SPARE, 16'($urandom));
        if (writes & WR_WIDTH)
            reg_write(cspc_pkg::REG_FRAME_WIDTH, w);
        if (writes & WR_HEIGHT)
            reg_write(cspc_pkg::REG_FRAME_HEIGHT, h);
        if (writes & WR_THRESH)
            reg_write(cspc_pkg::REG_PEAK_THRESHOLD, t);
        cfg_we <= 1'b0;
    endtask

    // block idle: nothing pending and the pipeline flushed
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_setting(input logic [2:0] writes, input logic [15:0] w,
                               input logic [15:0] h, input logic [15:0] t,
                               input int frames, input pix_style_t style_arg);
        int n;
        pix_style_t style;
        settle();
        load_config(writes, w, h, t);
        n = eff_width() * eff_height();
        repeat (frames)
        begin
            style = (style_arg == PIX_MIXED) ? pix_style_t'($urandom_range(3)) : style_arg;
            for (int k = 0; k < n; k++)
                send_pixel(pick_pixel(style));
        end
    endtask

    // count words out
    initial
    begin
        logic [cspc_pkg::OUT_W-1:0] want;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_counts.size() == 0)
                    report_mismatch("peak count with none pending", peak_count, '0);
                else
                begin
                    want = expected_counts.pop_front();
                    if (peak_count !== want)
                        report_mismatch("peak_count", peak_count, want);
                end
            end
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    initial
    begin
        int n;
        int start;
        frame_case_t fc;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        use_typed = 1'b0;
        typed_count = '0;
        pixels_sent = 0;
        mismatches = 0;
        cfg_width = cspc_pkg::FRAME_WIDTH_RST;
        cfg_height = cspc_pkg::FRAME_HEIGHT_RST;
        cfg_thresh = cspc_pkg::PEAK_THRESHOLD_RST;
        col_pos = 0;
        row_pos = 0;
        peaks = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
        begin
            fc = directed_cases[i];
            settle();
            load_config(fc.writes, fc.width_val, fc.height_val, fc.thresh_val);
            use_typed = 1'b1;
            typed_count = fc.count;
            n = eff_width() * eff_height();
            for (int k = 0; k < n; k++)
                send_pixel((k == eff_width() + 1) ? fc.centre : fc.fill);
            use_typed = 1'b0;
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin snd_idle_pct = 68; rcv_stall_pct = 0;  end
                2:       begin snd_idle_pct = 0;  rcv_stall_pct = 68; end
                default: begin snd_idle_pct = 12; rcv_stall_pct = 12; end
            endcase
            start = pixels_sent;
            while (pixels_sent - start < RANDOM_PIXELS / 4)
                run_setting(($urandom_range(99) < 80) ? WR_ALL : 3'($urandom_range(7, 1)),
                            pick_width(), pick_height(), pick_threshold(),
                            $urandom_range(3, 1), PIX_MIXED);
        end

        settle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
